@@ rtl/mjpc_pkg.sv @@
package mjpc_pkg;

    localparam int TUPLE_W = 64;
    localparam int KEY_STEP = 5;
    localparam int PROT_LSB = 14;
    localparam int PROT_W = 18;
    localparam int KMER_W = 4;
    localparam int COUNT_W = 16;
    localparam int LEN_W = 11;
    localparam int ACT_W = 3;
    localparam int IDX_W = 6;
    localparam logic [KMER_W-1:0] KMER_RESET = 4'd6;
    localparam int DEF_LIST_DEPTH = 1024;
    localparam int DEF_PROT_BITS = 6;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOAD_A    = 3'd0,
        ACT_LOAD_B    = 3'd1,
        ACT_JOIN      = 3'd2,
        ACT_SELF_JOIN = 3'd3,
        ACT_READ      = 3'd4,
        ACT_CLEAR     = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ASEL_P,
        ASEL_PE,
        ASEL_I,
        ASEL_J
    } a_sel_t;

    typedef enum logic [1:0] {
        BSEL_Q,
        BSEL_QE,
        BSEL_J
    } b_sel_t;

    typedef enum logic [4:0] {
        ST_RST_SWEEP,
        ST_IDLE,
        ST_DECODE,
        ST_AB_TEST,
        ST_AB_CMP,
        ST_SCAN_A,
        ST_SCAN_A_CMP,
        ST_SCAN_B,
        ST_SCAN_B_CMP,
        ST_SJ_TEST,
        ST_SJ_CMP,
        ST_RD_I,
        ST_CAP_I,
        ST_CAP_J,
        ST_INC,
        ST_READ_CAP,
        ST_SWEEP,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic   capture;
        logic   load_a_wr;
        logic   load_b_wr;
        logic   set_full;
        logic   init_walk;
        logic   p_inc;
        logic   q_inc;
        logic   start_run;
        logic   pe_inc;
        logic   qe_inc;
        logic   init_pairs_ab;
        logic   init_pairs_self;
        logic   cap_i;
        logic   cap_idx;
        logic   bump_wr;
        logic   set_range;
        logic   step_pair;
        logic   end_run;
        logic   pair_rd_read;
        logic   rc_cap;
        logic   clr_lists;
        logic   sweep_wr;
        logic   push;
        a_sel_t a_sel;
        b_sel_t b_sel;
    } ctl_cmd_t;

    typedef struct packed {
        logic [ACT_W-1:0] act;
        logic             is_self;
        logic             p_lt_a;
        logic             q_lt_b;
        logic             pe_lt_a;
        logic             qe_lt_b;
        logic             ka_lt_kb;
        logic             ka_gt_kb;
        logic             a_key_eq;
        logic             b_key_eq;
        logic             pair_ok;
        logic             i_last;
        logic             j_last;
        logic             a_full;
        logic             b_full;
        logic             sweep_last;
        logic             out_free;
    } dp_status_t;

    // The key is the top min(5k+1, 64) bits of the tuple.
    function automatic logic [TUPLE_W-1:0] key_of(input logic [TUPLE_W-1:0] w,
                                                  input logic [KMER_W-1:0] k);
        logic [6:0] nbits;
        logic [6:0] sh;
        nbits = 7'({3'b000, k} * 7'd5) + 7'd1;
        if (nbits > 7'd64)
        begin
            nbits = 7'd64;
        end
        sh = 7'd64 - nbits;
        return w >> sh;
    endfunction

endpackage

@@ rtl/mjpc_if.sv @@
interface mjpc_cmd_if;
    import mjpc_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACT_W-1:0]    action;
    logic [TUPLE_W-1:0]  tuple_word;
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    modport source(output valid, action, tuple_word, row_index, col_index, input ready);
    modport sink(input valid, action, tuple_word, row_index, col_index, output ready);
endinterface

interface mjpc_res_if;
    import mjpc_pkg::*;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] read_count;
    logic [LEN_W-1:0]   a_length;
    logic [LEN_W-1:0]   b_length;
    logic               full_flag;
    logic               range_flag;
    modport source(output valid, read_count, a_length, b_length, full_flag, range_flag,
                   input ready);
    modport sink(input valid, read_count, a_length, b_length, full_flag, range_flag,
                 output ready);
endinterface

@@ rtl/merge_join_pair_counter.sv @@
// Loads and unused actions pass from decode to done, a count read adds a capture state,
// and a clear zeroes every counter entry. A join steps through its merge, run-scan and
// pair-bump states, paced by each list memory's single read port and the counters' read-modify-write.
// One item is worked on at a time; a finished result waits in an output register.
// After reset the 4^PROT_BITS counter entries (4096 by default) are zeroed,
// one entry a cycle, before the first item is taken; the k-mer register resets to k = 6.
module merge_join_pair_counter #(
    parameter int LIST_DEPTH = mjpc_pkg::DEF_LIST_DEPTH,
    parameter int PROT_BITS = mjpc_pkg::DEF_PROT_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [mjpc_pkg::KMER_W-1:0] cfg_wdata,
    mjpc_cmd_if.sink                    cmd,
    mjpc_res_if.source                  result
);
    import mjpc_pkg::*;

    ctl_cmd_t   ctl_cmd;
    dp_status_t dp_status;

    mjpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (cmd.valid),
        .in_ready (cmd.ready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    mjpc_datapath #(.LIST_DEPTH(LIST_DEPTH), .PROT_BITS(PROT_BITS)) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .action     (cmd.action),
        .tuple_word (cmd.tuple_word),
        .row_index  (cmd.row_index),
        .col_index  (cmd.col_index),
        .cmd        (ctl_cmd),
        .status     (dp_status),
        .out_ready  (result.ready),
        .out_valid  (result.valid),
        .read_count (result.read_count),
        .a_length   (result.a_length),
        .b_length   (result.b_length),
        .full_flag  (result.full_flag),
        .range_flag (result.range_flag)
    );

endmodule

@@ rtl/mjpc_ram.sv @@
module mjpc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/mjpc_ctrl.sv @@
module mjpc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  mjpc_pkg::dp_status_t status,
    output mjpc_pkg::ctl_cmd_t   cmd
);
    import mjpc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RST_SWEEP;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                unique case (status.act)
                    ACT_JOIN:      state_next = ST_AB_TEST;
                    ACT_SELF_JOIN: state_next = ST_SJ_TEST;
                    ACT_READ:      state_next = ST_READ_CAP;
                    ACT_CLEAR:     state_next = ST_SWEEP;
                    default:       state_next = ST_DONE;
                endcase
            end
            ST_AB_TEST:
            begin
                state_next = (status.p_lt_a && status.q_lt_b) ? ST_AB_CMP : ST_DONE;
            end
            ST_AB_CMP:
            begin
                if (status.ka_lt_kb || status.ka_gt_kb)
                begin
                    state_next = ST_AB_TEST;
                end
                else
                begin
                    state_next = ST_SCAN_A;
                end
            end
            ST_SCAN_A:
            begin
                if (status.pe_lt_a)
                begin
                    state_next = ST_SCAN_A_CMP;
                end
                else
                begin
                    state_next = status.is_self ? ST_RD_I : ST_SCAN_B;
                end
            end
            ST_SCAN_A_CMP:
            begin
                if (status.a_key_eq)
                begin
                    state_next = ST_SCAN_A;
                end
                else
                begin
                    state_next = status.is_self ? ST_RD_I : ST_SCAN_B;
                end
            end
            ST_SCAN_B:
            begin
                state_next = status.qe_lt_b ? ST_SCAN_B_CMP : ST_RD_I;
            end
            ST_SCAN_B_CMP:
            begin
                state_next = status.b_key_eq ? ST_SCAN_B : ST_RD_I;
            end
            ST_SJ_TEST:
            begin
                state_next = status.p_lt_a ? ST_SJ_CMP : ST_DONE;
            end
            ST_SJ_CMP:
            begin
                state_next = ST_SCAN_A;
            end
            ST_RD_I:
            begin
                state_next = ST_CAP_I;
            end
            ST_CAP_I:
            begin
                state_next = ST_CAP_J;
            end
            ST_CAP_J, ST_INC:
            begin
                if ((state_reg == ST_CAP_J) && status.pair_ok)
                begin
                    state_next = ST_INC;
                end
                else if (status.i_last && status.j_last)
                begin
                    state_next = status.is_self ? ST_SJ_TEST : ST_AB_TEST;
                end
                else
                begin
                    state_next = ST_RD_I;
                end
            end
            ST_READ_CAP:
            begin
                state_next = ST_DONE;
            end
            ST_SWEEP:
            begin
                if (status.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.a_sel = ASEL_P;
        cmd.b_sel = BSEL_Q;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_RST_SWEEP, ST_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.capture = in_valid;
            end
            ST_DECODE:
            begin
                unique case (status.act)
                    ACT_LOAD_A:
                    begin
                        cmd.set_full = status.a_full;
                        cmd.load_a_wr = !status.a_full;
                    end
                    ACT_LOAD_B:
                    begin
                        cmd.set_full = status.b_full;
                        cmd.load_b_wr = !status.b_full;
                    end
                    ACT_JOIN, ACT_SELF_JOIN:
                    begin
                        cmd.init_walk = 1'b1;
                    end
                    ACT_READ:
                    begin
                        cmd.pair_rd_read = 1'b1;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clr_lists = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_AB_TEST, ST_SJ_TEST:
            begin
                cmd.a_sel = ASEL_P;
                cmd.b_sel = BSEL_Q;
            end
            ST_AB_CMP:
            begin
                if (status.ka_lt_kb)
                begin
                    cmd.p_inc = 1'b1;
                end
                else if (status.ka_gt_kb)
                begin
                    cmd.q_inc = 1'b1;
                end
                else
                begin
                    cmd.start_run = 1'b1;
                end
            end
            ST_SJ_CMP:
            begin
                cmd.start_run = 1'b1;
            end
            ST_SCAN_A:
            begin
                cmd.a_sel = ASEL_PE;
                cmd.init_pairs_self = !status.pe_lt_a && status.is_self;
            end
            ST_SCAN_A_CMP:
            begin
                cmd.pe_inc = status.a_key_eq;
                cmd.init_pairs_self = !status.a_key_eq && status.is_self;
            end
            ST_SCAN_B:
            begin
                cmd.b_sel = BSEL_QE;
                cmd.init_pairs_ab = !status.qe_lt_b;
            end
            ST_SCAN_B_CMP:
            begin
                cmd.qe_inc = status.b_key_eq;
                cmd.init_pairs_ab = !status.b_key_eq;
            end
            ST_RD_I:
            begin
                cmd.a_sel = ASEL_I;
                cmd.b_sel = BSEL_J;
            end
            ST_CAP_I:
            begin
                cmd.cap_i = 1'b1;
                cmd.a_sel = ASEL_J;
                cmd.b_sel = BSEL_J;
            end
            ST_CAP_J:
            begin
                cmd.b_sel = BSEL_J;
                cmd.cap_idx = 1'b1;
                if (!status.pair_ok)
                begin
                    cmd.set_range = 1'b1;
                    cmd.step_pair = 1'b1;
                    cmd.end_run = status.i_last && status.j_last;
                end
            end
            ST_INC:
            begin
                cmd.bump_wr = 1'b1;
                cmd.step_pair = 1'b1;
                cmd.end_run = status.i_last && status.j_last;
            end
            ST_READ_CAP:
            begin
                cmd.rc_cap = 1'b1;
            end
            ST_DONE:
            begin
                cmd.push = status.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ rtl/mjpc_datapath.sv @@
module mjpc_datapath #(
    parameter int LIST_DEPTH = mjpc_pkg::DEF_LIST_DEPTH,
    parameter int PROT_BITS = mjpc_pkg::DEF_PROT_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [mjpc_pkg::KMER_W-1:0]     cfg_wdata,
    input  logic [mjpc_pkg::ACT_W-1:0]      action,
    input  logic [mjpc_pkg::TUPLE_W-1:0]    tuple_word,
    input  logic [mjpc_pkg::IDX_W-1:0]      row_index,
    input  logic [mjpc_pkg::IDX_W-1:0]      col_index,
    input  mjpc_pkg::ctl_cmd_t              cmd,
    output mjpc_pkg::dp_status_t            status,
    input  logic                            out_ready,
    output logic                            out_valid,
    output logic [mjpc_pkg::COUNT_W-1:0]    read_count,
    output logic [mjpc_pkg::LEN_W-1:0]      a_length,
    output logic [mjpc_pkg::LEN_W-1:0]      b_length,
    output logic                            full_flag,
    output logic                            range_flag
);
    import mjpc_pkg::*;

    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int AW = $clog2(LIST_DEPTH);
    localparam int PAW = 2 * PROT_BITS;
    localparam int PAIR_DEPTH = 1 << PAW;
    localparam logic [PROT_W:0] ID_LIMIT = (PROT_W + 1)'(1) << PROT_BITS;

    logic [KMER_W-1:0]  kmer_reg;
    logic [CW-1:0]      a_count_reg;
    logic [CW-1:0]      b_count_reg;
    logic               full_reg;
    logic               range_reg;
    logic               out_valid_reg;
    logic [PAW-1:0]     sweep_reg;
    logic [ACT_W-1:0]   act_reg;
    logic [TUPLE_W-1:0] tuple_reg;
    logic [IDX_W-1:0]   row_reg;
    logic [IDX_W-1:0]   col_reg;
    logic [CW-1:0]      p_reg;
    logic [CW-1:0]      q_reg;
    logic [CW-1:0]      pe_reg;
    logic [CW-1:0]      qe_reg;
    logic [CW-1:0]      i_reg;
    logic [CW-1:0]      j_reg;
    logic [TUPLE_W-1:0] key_reg;
    logic [TUPLE_W-1:0] ta_reg;
    logic [PAW-1:0]     idx_reg;
    logic [COUNT_W-1:0] rc_reg;
    logic [COUNT_W-1:0] out_rc_reg;
    logic [LEN_W-1:0]   out_a_reg;
    logic [LEN_W-1:0]   out_b_reg;
    logic               out_full_reg;
    logic               out_range_reg;

    logic [TUPLE_W-1:0] a_rd;
    logic [TUPLE_W-1:0] b_rd;
    logic [COUNT_W-1:0] pair_rd;
    logic [AW-1:0]      a_raddr;
    logic [AW-1:0]      b_raddr;
    logic [PAW-1:0]     pair_raddr;
    logic               pair_we;
    logic [PAW-1:0]     pair_waddr;
    logic [COUNT_W-1:0] pair_wdata;
    logic [TUPLE_W-1:0] tb;
    logic [PROT_W-1:0]  pa;
    logic [PROT_W-1:0]  pb;
    logic [PAW-1:0]     bump_idx;
    logic [PROT_W-1:0]  row_ext;
    logic [PROT_W-1:0]  col_ext;
    logic [PAW-1:0]     read_idx;
    logic               read_ok;
    logic [TUPLE_W-1:0] ka;
    logic [TUPLE_W-1:0] kb;
    logic               is_self;

    assign is_self = (act_reg == ACT_SELF_JOIN);
    assign ka = key_of(a_rd, kmer_reg);
    assign kb = key_of(b_rd, kmer_reg);
    assign tb = is_self ? a_rd : b_rd;
    assign pa = ta_reg[PROT_LSB +: PROT_W];
    assign pb = tb[PROT_LSB +: PROT_W];
    assign bump_idx = {pa[PROT_BITS-1:0], pb[PROT_BITS-1:0]};
    assign row_ext = PROT_W'(row_reg);
    assign col_ext = PROT_W'(col_reg);
    assign read_idx = {row_ext[PROT_BITS-1:0], col_ext[PROT_BITS-1:0]};
    assign read_ok = ({1'b0, row_ext} < ID_LIMIT) && ({1'b0, col_ext} < ID_LIMIT);

    always_comb
    begin
        unique case (cmd.a_sel)
            ASEL_P:  a_raddr = p_reg[AW-1:0];
            ASEL_PE: a_raddr = pe_reg[AW-1:0];
            ASEL_I:  a_raddr = i_reg[AW-1:0];
            ASEL_J:  a_raddr = j_reg[AW-1:0];
            default: a_raddr = p_reg[AW-1:0];
        endcase
        unique case (cmd.b_sel)
            BSEL_Q:  b_raddr = q_reg[AW-1:0];
            BSEL_QE: b_raddr = qe_reg[AW-1:0];
            BSEL_J:  b_raddr = j_reg[AW-1:0];
            default: b_raddr = q_reg[AW-1:0];
        endcase
    end

    assign pair_raddr = cmd.pair_rd_read ? read_idx : bump_idx;
    assign pair_we = cmd.bump_wr || cmd.sweep_wr;
    assign pair_waddr = cmd.sweep_wr ? sweep_reg : idx_reg;
    assign pair_wdata = cmd.sweep_wr ? '0 : pair_rd + COUNT_W'(1);

    mjpc_ram #(.WIDTH(TUPLE_W), .DEPTH(LIST_DEPTH)) u_list_a (
        .clk   (clk),
        .we    (cmd.load_a_wr),
        .waddr (a_count_reg[AW-1:0]),
        .wdata (tuple_reg),
        .raddr (a_raddr),
        .rdata (a_rd)
    );

    mjpc_ram #(.WIDTH(TUPLE_W), .DEPTH(LIST_DEPTH)) u_list_b (
        .clk   (clk),
        .we    (cmd.load_b_wr),
        .waddr (b_count_reg[AW-1:0]),
        .wdata (tuple_reg),
        .raddr (b_raddr),
        .rdata (b_rd)
    );

    mjpc_ram #(.WIDTH(COUNT_W), .DEPTH(PAIR_DEPTH)) u_pairs (
        .clk   (clk),
        .we    (pair_we),
        .waddr (pair_waddr),
        .wdata (pair_wdata),
        .raddr (pair_raddr),
        .rdata (pair_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kmer_reg <= KMER_RESET;
            a_count_reg <= '0;
            b_count_reg <= '0;
            full_reg <= 1'b0;
            range_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                kmer_reg <= cfg_wdata;
            end
            if (cmd.load_a_wr)
            begin
                a_count_reg <= a_count_reg + CW'(1);
            end
            if (cmd.load_b_wr)
            begin
                b_count_reg <= b_count_reg + CW'(1);
            end
            if (cmd.clr_lists)
            begin
                a_count_reg <= '0;
                b_count_reg <= '0;
            end
            if (cmd.set_full)
            begin
                full_reg <= 1'b1;
            end
            if (cmd.set_range)
            begin
                range_reg <= 1'b1;
            end
            if (cmd.sweep_wr)
            begin
                sweep_reg <= sweep_reg + PAW'(1);
            end
            if (cmd.push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            tuple_reg <= tuple_word;
            row_reg <= row_index;
            col_reg <= col_index;
            rc_reg <= '0;
        end
        if (cmd.rc_cap)
        begin
            rc_reg <= read_ok ? pair_rd : '0;
        end
        if (cmd.init_walk)
        begin
            p_reg <= '0;
            q_reg <= '0;
        end
        if (cmd.p_inc)
        begin
            p_reg <= p_reg + CW'(1);
        end
        if (cmd.q_inc)
        begin
            q_reg <= q_reg + CW'(1);
        end
        if (cmd.start_run)
        begin
            key_reg <= ka;
            pe_reg <= p_reg + CW'(1);
            qe_reg <= q_reg + CW'(1);
        end
        if (cmd.pe_inc)
        begin
            pe_reg <= pe_reg + CW'(1);
        end
        if (cmd.qe_inc)
        begin
            qe_reg <= qe_reg + CW'(1);
        end
        if (cmd.init_pairs_ab)
        begin
            i_reg <= p_reg;
            j_reg <= q_reg;
        end
        if (cmd.init_pairs_self)
        begin
            q_reg <= p_reg;
            qe_reg <= pe_reg;
            i_reg <= p_reg;
            j_reg <= p_reg;
        end
        if (cmd.cap_i)
        begin
            ta_reg <= a_rd;
        end
        if (cmd.cap_idx)
        begin
            idx_reg <= bump_idx;
        end
        if (cmd.step_pair)
        begin
            if (status.j_last)
            begin
                j_reg <= q_reg;
                i_reg <= i_reg + CW'(1);
            end
            else
            begin
                j_reg <= j_reg + CW'(1);
            end
        end
        if (cmd.end_run)
        begin
            p_reg <= pe_reg;
            q_reg <= qe_reg;
        end
        if (cmd.push)
        begin
            out_rc_reg <= rc_reg;
            out_a_reg <= LEN_W'(a_count_reg);
            out_b_reg <= LEN_W'(b_count_reg);
            out_full_reg <= full_reg;
            out_range_reg <= range_reg;
        end
    end

    always_comb
    begin
        status.act = act_reg;
        status.is_self = is_self;
        status.p_lt_a = (p_reg < a_count_reg);
        status.q_lt_b = (q_reg < b_count_reg);
        status.pe_lt_a = (pe_reg < a_count_reg);
        status.qe_lt_b = (qe_reg < b_count_reg);
        status.ka_lt_kb = (ka < kb);
        status.ka_gt_kb = (ka > kb);
        status.a_key_eq = (ka == key_reg);
        status.b_key_eq = (kb == key_reg);
        status.pair_ok = ({1'b0, pa} < ID_LIMIT) && ({1'b0, pb} < ID_LIMIT);
        status.i_last = ((i_reg + CW'(1)) == pe_reg);
        status.j_last = ((j_reg + CW'(1)) == qe_reg);
        status.a_full = (a_count_reg == CW'(LIST_DEPTH));
        status.b_full = (b_count_reg == CW'(LIST_DEPTH));
        status.sweep_last = &sweep_reg;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign read_count = out_rc_reg;
    assign a_length = out_a_reg;
    assign b_length = out_b_reg;
    assign full_flag = out_full_reg;
    assign range_flag = out_range_reg;

endmodule
